// ----- hdl/lrute_pkg.sv -----
// Shared types and constants for the LRU touch/evict list.
package lrute_pkg;

    localparam int          DEPTH_DEFAULT = 64;
    localparam int          CAP_W         = 7;
    localparam int          OCC_W         = 7;
    localparam logic [6:0]  CAP_RESET     = 7'd50;

    typedef struct packed {
        logic [1:0]  category;
        logic [30:0] object_id;
    } t_key;

    // What every cell hands to its neighbours.
    typedef struct packed {
        t_key value;
        logic match;
        logic pre;
    } t_cell_out;

    // Control common to the whole row of cells.
    typedef struct packed {
        t_key key;
        logic cmp_en;
        logic upd_en;
        logic evict;
    } t_cell_ctl;

endpackage

// ----- hdl/lrute_cell.sv -----
// One slot of the recency row: holds a key, compares it and shifts towards the old end.
module lrute_cell
    import lrute_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 2),
    parameter int IDX   = 0
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  logic [CW-1:0] i_final,
    input  logic          i_pre,
    input  t_cell_out     i_next,
    input  t_key          i_next2,
    output t_cell_out     o_cell
);

    localparam logic [CW-1:0] THIS_IDX = CW'(IDX);
    localparam logic [CW-1:0] LAST_CNT = CW'(IDX + 1);

    t_key r_value;
    logic r_match;
    t_key n_value;
    logic pre_here;

    assign pre_here = i_pre | r_match;

    always_comb begin
        if (i_final == LAST_CNT) begin
            // new most-recent slot
            n_value = i_ctl.key;
        end else if (!i_ctl.evict) begin
            n_value = pre_here ? i_next.value : r_value;
        end else begin
            n_value = i_next.pre ? i_next2 : i_next.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_match <= (i_count > THIS_IDX) && (r_value == i_ctl.key);
        end
        if (i_ctl.upd_en) begin
            r_value <= n_value;
        end
    end

    assign o_cell.value = r_value;
    assign o_cell.match = r_match;
    assign o_cell.pre   = pre_here;

endmodule

// ----- hdl/lru_touch_evict_list_unit.sv -----
// Top level of the LRU touch/evict list: cell row, control and result register.
//
// Usage:
//   Input channel: i_valid / o_stall carry one touch (i_category, i_object_id).
//   A transfer happens at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry one result per touch (hit flag,
//   eviction flag with the evicted key, occupancy after the touch).
//   Configuration: i_cfg_we writes i_cfg_wdata into the capacity register;
//   write only while no touch is in flight. Capacity above DEPTH acts as DEPTH.
//
// Sequence: a touch passes through S_IDLE, where the transfer happens, then
// S_CMP, in which every cell compares its key with the touched key (match bits
// registered), then S_UPD, in which the row shifts and the result register is
// loaded. The prefix of match bits ripples along the row of cells, which sets
// the timing of the S_UPD step. A new touch is taken only back in S_IDLE.
//
// Reset (synchronous, i_rst_n low) empties the list, sets capacity to 50 and
// drops any pending result. If the receiver stalls, the result is held and
// one further touch may be taken; its update then waits for the transfer.
module lru_touch_evict_list_unit
    import lrute_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    // touch channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_category,
    input  logic [30:0] i_object_id,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic        o_evicted,
    output logic [1:0]  o_evicted_category,
    output logic [30:0] o_evicted_id,
    output logic [6:0]  o_occupancy
);

    localparam int CW   = $clog2(DEPTH + 2);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} t_state;

    t_state          r_state;
    t_key            r_key;
    logic [CW-1:0]   r_count;
    logic [6:0]      r_capacity;
    logic            r_out_valid;
    logic            r_hit;
    logic            r_evicted;
    t_key            r_victim;
    logic [OCC_W-1:0] r_occ;

    t_cell_out       cell_out [DEPTH];
    t_cell_ctl       ctl;

    logic            in_xfer;
    logic            out_free;
    logic            hit;
    logic [CW-1:0]   touch_count;
    logic [CMPW-1:0] cap_w;
    logic [CMPW-1:0] eff_cap;
    logic            evict;
    logic [CW-1:0]   n_count;
    t_key            victim;

    assign in_xfer  = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // Decision logic, valid in the update cycle once match bits are settled.
    assign hit         = cell_out[DEPTH-1].pre;
    assign touch_count = hit ? r_count : r_count + CW'(1);
    assign cap_w       = CMPW'(r_capacity);
    assign eff_cap     = (cap_w > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_w;
    assign evict       = CMPW'(touch_count) > eff_cap;
    assign n_count     = touch_count - CW'(evict);

    // Oldest entry after the touch: the touched key itself when it is alone,
    // the second slot when the oldest was the hit, else the oldest slot.
    always_comb begin
        if (touch_count == CW'(1)) begin
            victim = r_key;
        end else if (cell_out[0].match) begin
            victim = cell_out[1].value;
        end else begin
            victim = cell_out[0].value;
        end
    end

    assign ctl.key    = r_key;
    assign ctl.cmp_en = (r_state == S_CMP);
    assign ctl.upd_en = (r_state == S_UPD) && out_free;
    assign ctl.evict  = evict;

    // Row of cells, slot 0 holds the least recent key.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic pre_in;
        t_cell_out next_out;
        t_key next2_val;

        if (g == 0) begin : g_first
            assign pre_in = 1'b0;
        end else begin : g_mid
            assign pre_in = cell_out[g-1].pre;
        end

        if (g + 1 < DEPTH) begin : g_n1
            assign next_out = cell_out[g+1];
        end else begin : g_n1_end
            assign next_out = '0;
        end

        if (g + 2 < DEPTH) begin : g_n2
            assign next2_val = cell_out[g+2].value;
        end else begin : g_n2_end
            assign next2_val = '0;
        end

        lrute_cell #(
            .DEPTH (DEPTH),
            .CW    (CW),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_count (r_count),
            .i_final (n_count),
            .i_pre   (pre_in),
            .i_next  (next_out),
            .i_next2 (next2_val),
            .o_cell  (cell_out[g])
        );
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Sequencer, occupancy and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result when the update runs, else drop it on transfer
            if ((r_state == S_UPD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_key.category  <= i_category;
                        r_key.object_id <= i_object_id;
                        r_state         <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    // hold until the result register is free
                    if (out_free) begin
                        r_count     <= n_count;
                        r_hit       <= hit;
                        r_evicted   <= evict;
                        r_victim    <= evict ? victim : '0;
                        r_occ       <= OCC_W'(n_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_hit              = r_hit;
    assign o_evicted          = r_evicted;
    assign o_evicted_category = r_victim.category;
    assign o_evicted_id       = r_victim.object_id;
    assign o_occupancy        = r_occ;

endmodule

// ----- sim/tb_lru_touch_evict_list_unit.sv -----
// Self-checking testbench for the LRU touch/evict list: directed script, then random phases.
module tb_lru_touch_evict_list_unit
    import lrute_pkg::*;
();

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_CYCLES     = 8;
    localparam int POOL_MAX       = 100;

    // One result as the block reports it.
    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [1:0]  category;
        logic [30:0] object_id;
        logic [6:0]  occupancy;
    } t_touch_result;

    typedef enum logic {
        ROW_TOUCH,
        ROW_CAPACITY
    } t_row_kind;

    // One line of the directed script: either a touch or a capacity write.
    // Where pinned is set, the expected result is the one typed in the row.
    typedef struct {
        t_row_kind     kind;
        logic [1:0]    category;
        logic [30:0]   object_id;
        logic [6:0]    capacity;
        bit            pinned;
        t_touch_result want;
    } t_script_row;

    localparam t_touch_result NO_RESULT = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_category;
    logic [30:0] i_object_id;
    logic        o_valid;
    logic        i_stall;
    logic        o_hit;
    logic        o_evicted;
    logic [1:0]  o_evicted_category;
    logic [30:0] o_evicted_id;
    logic [6:0]  o_occupancy;

    // Sideband that travels with the touch payload: a typed expectation for
    // the directed rows that can be read off at a glance.
    logic          pin_expect;
    t_touch_result pinned_result;

    // Predictor state: keys held, oldest at the front, and the capacity register.
    t_key          recency_q[$];
    logic [6:0]    capacity_reg;
    t_touch_result pending_results[$];

    int  error_count;
    int  touches_sent;
    int  results_seen;
    int  idle_cycles;
    bit  idle_en;

    t_script_row directed_script[21] = '{
        // capacity zero on an empty list: the touched key evicts itself
        '{ROW_CAPACITY, 2'd0, 31'd0,          7'd0,   1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd2, 31'h2AAA_AAAA,  7'd0,   1'b1,
          '{1'b0, 1'b1, 2'd2, 31'h2AAA_AAAA, 7'd0}},
        '{ROW_TOUCH,    2'd2, 31'h2AAA_AAAA,  7'd0,   1'b1,
          '{1'b0, 1'b1, 2'd2, 31'h2AAA_AAAA, 7'd0}},
        '{ROW_TOUCH,    2'd1, 31'h5555_5555,  7'd0,   1'b0, NO_RESULT},
        // capacity above the list depth saturates
        '{ROW_CAPACITY, 2'd0, 31'd0,          7'd127, 1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd0, 31'd0,          7'd0,   1'b1,
          '{1'b0, 1'b0, 2'd0, 31'd0, 7'd1}},
        '{ROW_TOUCH,    2'd3, 31'h7FFF_FFFF,  7'd0,   1'b1,
          '{1'b0, 1'b0, 2'd0, 31'd0, 7'd2}},
        '{ROW_TOUCH,    2'd0, 31'd0,          7'd0,   1'b1,
          '{1'b1, 1'b0, 2'd0, 31'd0, 7'd2}},
        '{ROW_TOUCH,    2'd1, 31'h5555_5555,  7'd0,   1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd2, 31'h2AAA_AAAA,  7'd0,   1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd3, 31'h7FFF_FFFF,  7'd0,   1'b0, NO_RESULT},
        // capacity lowered below occupancy: shrink one key per touch, hits too
        '{ROW_CAPACITY, 2'd0, 31'd0,          7'd1,   1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd1, 31'h5555_5555,  7'd0,   1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd0, 31'h0123_4567,  7'd0,   1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd0, 31'h0123_4567,  7'd0,   1'b0, NO_RESULT},
        '{ROW_CAPACITY, 2'd0, 31'd0,          7'd64,  1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd3, 31'd0,          7'd0,   1'b0, NO_RESULT},
        // capacity zero with keys still held
        '{ROW_CAPACITY, 2'd0, 31'd0,          7'd0,   1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd2, 31'd0,          7'd0,   1'b0, NO_RESULT},
        '{ROW_TOUCH,    2'd3, 31'd0,          7'd0,   1'b0, NO_RESULT},
        '{ROW_CAPACITY, 2'd0, 31'd0,          7'd50,  1'b0, NO_RESULT}
    };

    lru_touch_evict_list_unit #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_category         (i_category),
        .i_object_id        (i_object_id),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_hit              (o_hit),
        .o_evicted          (o_evicted),
        .o_evicted_category (o_evicted_category),
        .o_evicted_id       (o_evicted_id),
        .o_occupancy        (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Print one line per failure and count it; the run carries on.
    task automatic report_failure(string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Advance the recency list by one touch and return the result it reports.
    function automatic t_touch_result apply_touch(t_key key);
        t_touch_result res;
        t_key          victim;
        int            pos;
        int            limit;
        res = '0;
        pos = -1;
        foreach (recency_q[n]) begin
            if (pos < 0 && recency_q[n] == key) pos = n;
        end
        if (pos >= 0) begin
            // hit: move the key to the most-recent end
            recency_q.delete(pos);
            recency_q.push_back(key);
            res.hit = 1'b1;
        end else if (recency_q.size() <= DEPTH) begin
            recency_q.push_back(key);
        end
        limit = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
        if (recency_q.size() > limit && recency_q.size() > 0) begin
            // drop only the single oldest key, however far over capacity
            victim            = recency_q.pop_front();
            res.evicted       = 1'b1;
            res.category      = victim.category;
            res.object_id     = victim.object_id;
        end
        res.occupancy = 7'(recency_q.size());
        return res;
    endfunction

    // Offer one touch after a random gap and hold it until the transfer.
    task automatic send_touch(logic [1:0] category, logic [30:0] object_id,
                              bit pin, t_touch_result want);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_category    <= category;
        i_object_id   <= object_id;
        pin_expect    <= pin;
        pinned_result <= want;
        do @(posedge i_clk); while (o_stall);
        touches_sent++;
    endtask

    // Hold off the sender until every result is back, then write capacity.
    task automatic write_capacity(logic [6:0] value);
        i_valid <= 1'b0;
        while (results_seen != touches_sent) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Result side: alternate stall bursts with runs of ready cycles.
    initial begin : result_stall
        int hold;
        hold = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (idle_en && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                hold = idle_len();
            end else begin
                i_stall <= 1'b0;
                hold = $urandom_range(0, 15);
            end
        end
    end

    // Monitor: track configuration, predict on each touch transfer, check
    // each result transfer against the oldest expectation, watch for hangs.
    always @(posedge i_clk) begin : monitor
        t_touch_result want;
        t_touch_result predicted;
        t_key          key;
        bit            moved;
        if (!i_rst_n) begin
            recency_q.delete();
            pending_results.delete();
            capacity_reg = CAP_RESET;
            idle_cycles  = 0;
        end else begin
            moved = 1'b0;
            if (i_cfg_we) capacity_reg = i_cfg_wdata;

            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with nothing pending",
                                             results_seen));
                end else begin
                    want = pending_results.pop_front();
                    if (o_hit !== want.hit)
                        report_failure($sformatf("result %0d: hit %b, want %b",
                                                 results_seen, o_hit, want.hit));
                    if (o_evicted !== want.evicted)
                        report_failure($sformatf("result %0d: evicted %b, want %b",
                                                 results_seen, o_evicted, want.evicted));
                    if (o_evicted_category !== want.category)
                        report_failure($sformatf("result %0d: evicted category %0d, want %0d",
                                                 results_seen, o_evicted_category,
                                                 want.category));
                    if (o_evicted_id !== want.object_id)
                        report_failure($sformatf("result %0d: evicted id %h, want %h",
                                                 results_seen, o_evicted_id,
                                                 want.object_id));
                    if (o_occupancy !== want.occupancy)
                        report_failure($sformatf("result %0d: occupancy %0d, want %0d",
                                                 results_seen, o_occupancy,
                                                 want.occupancy));
                end
                results_seen++;
            end

            if (i_valid && !o_stall) begin
                moved         = 1'b1;
                key.category  = i_category;
                key.object_id = i_object_id;
                // always advance the predictor, even for rows with a typed result
                predicted = apply_touch(key);
                pending_results.push_back(pin_expect ? pinned_result : predicted);
            end

            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_key       pool[POOL_MAX];
        logic [6:0] phase_caps[8];
        logic [6:0] cap_value;
        t_key       key;
        int         eff;
        int         pool_n;
        int         items;

        error_count  = 0;
        touches_sent = 0;
        results_seen = 0;
        idle_en      = 1'b1;
        phase_caps   = '{7'd127, 7'd0, 7'd64, 7'd1, 7'd2, 7'd65, 7'd50, 7'd33};

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_valid       <= 1'b0;
        i_category    <= '0;
        i_object_id   <= '0;
        pin_expect    <= 1'b0;
        pinned_result <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script: extremes, capacity corner cases, hits at both ends.
        foreach (directed_script[n]) begin
            if (directed_script[n].kind == ROW_CAPACITY)
                write_capacity(directed_script[n].capacity);
            else
                send_touch(directed_script[n].category, directed_script[n].object_id,
                           directed_script[n].pinned, directed_script[n].want);
        end

        // Random phases: one capacity each, touches drawn mostly from a key
        // pool sized around that capacity so that hits and evictions mix.
        for (int phase = 0; phase < 8; phase++) begin
            cap_value = (phase == 6) ? 7'($urandom_range(3, 126)) : phase_caps[phase];
            write_capacity(cap_value);
            idle_en = (phase % 3 != 2);
            eff = (int'(cap_value) > DEPTH) ? DEPTH : int'(cap_value);
            if (eff >= 50) begin
                // enough distinct keys to fill the whole list
                items  = 120;
                pool_n = 96;
            end else begin
                items  = 50;
                pool_n = $urandom_range(2, eff + eff / 2 + 2);
            end
            for (int n = 0; n < pool_n; n++) begin
                pool[n].category  = 2'($urandom_range(0, 3));
                pool[n].object_id = 31'($urandom);
            end
            for (int n = 0; n < items; n++) begin
                if ($urandom_range(0, 99) < 80) begin
                    key = pool[$urandom_range(0, pool_n - 1)];
                end else begin
                    key.category  = 2'($urandom_range(0, 3));
                    key.object_id = 31'($urandom);
                end
                send_touch(key.category, key.object_id, 1'b0, NO_RESULT);
            end
        end

        // Drain: wait for every result, then watch for strays before the final check.
        idle_en = 1'b0;
        i_valid <= 1'b0;
        while (results_seen != touches_sent) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_failure($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/lrute_pkg.sv
hdl/lrute_cell.sv
hdl/lru_touch_evict_list_unit.sv
sim/tb_lru_touch_evict_list_unit.sv
